FILE: sv/bffth_pkg.sv
// Shared types, constants and codes for the FNV three-hash Bloom filter.
package bffth_pkg;

   localparam int unsigned FILTER_BITS = 65536;
   localparam int unsigned IDX_W       = $clog2(FILTER_BITS);
   localparam int unsigned MIX_SHIFT   = 16;

   localparam logic [63:0] FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
   // FNV prime is 2^40 + 0x1B3
   localparam int unsigned FNV_PRIME_SH = 40;
   localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;
   localparam logic [63:0] GOLDEN       = 64'h9E37_79B9_7F4A_7C15;

   typedef struct packed {
      logic       req_type;
      logic [7:0] name_byte;
      logic       is_last;
      logic       no_byte;
   } req_item_type;

   typedef struct packed {
      logic maybe_present;
      logic was_insert;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_ACC1,
      ST_ACC2,
      ST_ACC3,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_LOW,
      MUL_CROSS_LO,
      MUL_CROSS_HI
   } mul_op_type;

   typedef enum logic [1:0] {
      IDX_H1,
      IDX_H2,
      IDX_H3,
      IDX_CLEAR
   } idx_sel_type;

   typedef struct packed {
      logic        fold_en;
      logic        hash_rst;
      mul_op_type  mul_op;
      idx_sel_type idx_sel;
      logic        mem_we;
      logic        mem_wdata;
      logic        mem_re;
      logic        pres_first;
      logic        pres_and;
      logic        rsp_load;
      logic        rsp_query;
      logic        clr_adv;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
   } stat_type;

endpackage

FILE: sv/bffth_store.sv
// Single-bit filter store with one write and one registered read per cycle.
module bffth_store (
   input  logic                      clock,
   input  logic                      we,
   input  logic                      re,
   input  logic [bffth_pkg::IDX_W-1:0] addr,
   input  logic                      wdata,
   output logic                      rdata
);

   logic mem [bffth_pkg::FILTER_BITS];
   logic rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rd_ff <= mem[addr];
      end
   end

   assign rdata = rd_ff;

endmodule

FILE: sv/bffth_dp.sv
// Datapath: FNV-1a fold, golden-ratio multiply, index select, store and result register.
module bffth_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              name_byte,
   input  bffth_pkg::cmd_type      cmd,
   output bffth_pkg::stat_type     stat,
   output bffth_pkg::rsp_item_type rsp_item
);

   logic [63:0]                 h_ff, h_in;
   logic [63:0]                 acc_ff, acc_in;
   logic                        pres_ff, pres_in;
   logic [bffth_pkg::IDX_W-1:0] clr_addr_ff, clr_addr_in;
   bffth_pkg::rsp_item_type     rsp_ff, rsp_in;

   logic [63:0] fold_x;
   logic [72:0] fold_prod;
   logic [63:0] fold_next;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [63:0] h3;
   logic [bffth_pkg::IDX_W-1:0] addr;
   logic        rdata;

   // sign-extend the byte, xor in, multiply by the FNV prime as shift plus small product
   assign fold_x    = h_ff ^ {{56{name_byte[7]}}, name_byte};
   assign fold_prod = fold_x * bffth_pkg::FNV_PRIME_LO;
   assign fold_next = (fold_x << bffth_pkg::FNV_PRIME_SH) + fold_prod[63:0];

   always_comb begin
      case (cmd.mul_op)
         bffth_pkg::MUL_CROSS_HI: mul_a = h_ff[63:32];
         default:                 mul_a = h_ff[31:0];
      endcase
      case (cmd.mul_op)
         bffth_pkg::MUL_CROSS_LO: mul_b = bffth_pkg::GOLDEN[63:32];
         default:                 mul_b = bffth_pkg::GOLDEN[31:0];
      endcase
   end

   assign mul_p = mul_a * mul_b;
   assign h3    = h_ff ^ (acc_ff >> bffth_pkg::MIX_SHIFT);

   always_comb begin
      h_in = h_ff;
      if (cmd.hash_rst) begin
         h_in = bffth_pkg::FNV_BASIS;
      end else if (cmd.fold_en) begin
         h_in = fold_next;
      end

      acc_in = acc_ff;
      case (cmd.mul_op) inside
         bffth_pkg::MUL_LOW:      acc_in = mul_p;
         bffth_pkg::MUL_CROSS_LO,
         bffth_pkg::MUL_CROSS_HI: acc_in = {acc_ff[63:32] + mul_p[31:0], acc_ff[31:0]};
         default:                 acc_in = acc_ff;
      endcase

      pres_in = pres_ff;
      if (cmd.pres_first) begin
         pres_in = rdata;
      end else if (cmd.pres_and) begin
         pres_in = pres_ff & rdata;
      end

      clr_addr_in = cmd.clr_adv ? clr_addr_ff + 1'b1 : clr_addr_ff;

      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.maybe_present = cmd.rsp_query & pres_ff & rdata;
         rsp_in.was_insert    = ~cmd.rsp_query;
      end
   end

   // filter size is a power of two, so the modulo keeps the low bits
   always_comb begin
      unique case (cmd.idx_sel)
         bffth_pkg::IDX_H1:    addr = h_ff[bffth_pkg::IDX_W-1:0];
         bffth_pkg::IDX_H2:    addr = acc_ff[bffth_pkg::IDX_W-1:0];
         bffth_pkg::IDX_H3:    addr = h3[bffth_pkg::IDX_W-1:0];
         bffth_pkg::IDX_CLEAR: addr = clr_addr_ff;
         default:              addr = clr_addr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff        <= bffth_pkg::FNV_BASIS;
         clr_addr_ff <= '0;
      end else begin
         h_ff        <= h_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      pres_ff <= pres_in;
      rsp_ff  <= rsp_in;
   end

   bffth_store u_store (
      .clock (clock),
      .we    (cmd.mem_we),
      .re    (cmd.mem_re),
      .addr  (addr),
      .wdata (cmd.mem_wdata),
      .rdata (rdata)
   );

   assign stat.clr_last = (clr_addr_ff == '1);
   assign rsp_item      = rsp_ff;

endmodule

FILE: sv/bffth_ctrl.sv
// Controller: clearing sweep, byte intake, multiply steps, store accesses, result handoff.
module bffth_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bffth_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  bffth_pkg::stat_type     stat,
   output bffth_pkg::cmd_type      cmd
);

   bffth_pkg::state_type state_ff, state_in;
   logic                 query_ff, query_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bffth_pkg::ST_CLEAR;
         query_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         query_ff     <= query_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      query_in      = query_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      cmd           = '0;
      cmd.mul_op    = bffth_pkg::MUL_NONE;
      cmd.idx_sel   = bffth_pkg::IDX_H1;
      cmd.rsp_query = query_ff;
      unique case (state_ff)
         bffth_pkg::ST_CLEAR: begin
            cmd.mem_we  = 1'b1;
            cmd.idx_sel = bffth_pkg::IDX_CLEAR;
            cmd.clr_adv = 1'b1;
            if (stat.clr_last) begin
               state_in = bffth_pkg::ST_IDLE;
            end
         end
         bffth_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.fold_en = ~req_item.no_byte;
               if (req_item.is_last) begin
                  query_in = req_item.req_type;
                  state_in = bffth_pkg::ST_MUL0;
               end
            end
         end
         bffth_pkg::ST_MUL0: begin
            cmd.mul_op = bffth_pkg::MUL_LOW;
            state_in   = bffth_pkg::ST_MUL1;
         end
         bffth_pkg::ST_MUL1: begin
            cmd.mul_op = bffth_pkg::MUL_CROSS_LO;
            state_in   = bffth_pkg::ST_MUL2;
         end
         bffth_pkg::ST_MUL2: begin
            cmd.mul_op = bffth_pkg::MUL_CROSS_HI;
            state_in   = bffth_pkg::ST_ACC1;
         end
         bffth_pkg::ST_ACC1: begin
            cmd.idx_sel   = bffth_pkg::IDX_H1;
            cmd.mem_we    = ~query_ff;
            cmd.mem_wdata = 1'b1;
            cmd.mem_re    = query_ff;
            state_in      = bffth_pkg::ST_ACC2;
         end
         bffth_pkg::ST_ACC2: begin
            cmd.idx_sel    = bffth_pkg::IDX_H2;
            cmd.mem_we     = ~query_ff;
            cmd.mem_wdata  = 1'b1;
            cmd.mem_re     = query_ff;
            cmd.pres_first = 1'b1;
            state_in       = bffth_pkg::ST_ACC3;
         end
         bffth_pkg::ST_ACC3: begin
            cmd.idx_sel   = bffth_pkg::IDX_H3;
            cmd.mem_we    = ~query_ff;
            cmd.mem_wdata = 1'b1;
            cmd.mem_re    = query_ff;
            cmd.pres_and  = 1'b1;
            state_in      = bffth_pkg::ST_DONE;
         end
         bffth_pkg::ST_DONE: begin
            // hold until the result register is free or being drained
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               cmd.hash_rst = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = bffth_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bffth_pkg::ST_CLEAR;
         end
      endcase
   end

   assign req_stall = (state_ff != bffth_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/bloom_filter_fnv_three_hash.sv
// Top level of the FNV three-hash Bloom filter.
//
//   channel  | ports                              | moves
//   ---------+------------------------------------+-------------------------------
//   request  | req_valid, req_stall, req_item     | at most one name byte per item
//   response | rsp_valid, rsp_stall, rsp_item     | one result per last item
//
// A byte item is folded into the hash as it is taken. A last item runs through fold, three
// steps of the shared 32x32 multiplier for h2, three filter store accesses, result load.
// After reset the store is cleared one bit a cycle, all 65536 bits, with req_stall high.
// The result register lets byte intake go on while a result waits; a finished
// last item holds in its final step while rsp_stall keeps the result register full.
module bloom_filter_fnv_three_hash (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bffth_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output bffth_pkg::rsp_item_type rsp_item
);

   bffth_pkg::cmd_type  cmd;
   bffth_pkg::stat_type stat;

   bffth_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bffth_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .name_byte (req_item.name_byte),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: sv/bffth_checker.sv
// Port-level checks for the Bloom filter top level, bound to it.
module bffth_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input bffth_pkg::req_item_type req_item,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input bffth_pkg::rsp_item_type rsp_item
);

   // a waiting result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_item))
      else $error("stalled result changed");

   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.maybe_present && rsp_item.was_insert))
      else $error("insert result reports presence");

   // a finished name closes the intake as its hash work begins
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_item.is_last |=> req_stall ##1 req_stall)
      else $error("intake open during hash work");

endmodule

bind bloom_filter_fnv_three_hash bffth_checker u_checker (.*);

FILE: dv/bloom_filter_fnv_three_hash_tb.sv
// Self-checking testbench for the FNV three-hash Bloom filter: directed and random names.
`timescale 1ns / 1ps

module bloom_filter_fnv_three_hash_tb;

   localparam int unsigned FILTER_SIZE = bffth_pkg::FILTER_BITS;
   localparam logic [63:0] HASH_SEED   = 64'hCBF2_9CE4_8422_2325;
   localparam logic [63:0] HASH_PRIME  = 64'h0000_0100_0000_01B3;
   localparam logic [63:0] MIX_MULT    = 64'h9E37_79B9_7F4A_7C15;
   localparam int unsigned MIX_BITS    = 16;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;
   localparam logic IS_LAST    = 1'b1;
   localparam logic NOT_LAST   = 1'b0;
   localparam logic NO_BYTE    = 1'b1;
   localparam logic HAS_BYTE   = 1'b0;
   localparam logic TYPED      = 1'b1;
   localparam logic PREDICT    = 1'b0;

   localparam int DIR_ROWS     = 23;
   localparam int RAND_ITEMS   = 400;
   localparam int LIB_SIZE     = 32;
   localparam int MAX_NAME     = 6;
   localparam int DRAIN_CYCLES = 24;
   localparam int MAX_GAP      = 11;

   typedef struct packed {
      bffth_pkg::req_item_type item;
      logic                    typed;
      bffth_pkg::rsp_item_type exp;
   } dir_row_type;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   bffth_pkg::req_item_type req_item  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   bffth_pkg::rsp_item_type rsp_item;

   // model state
   logic [63:0]             name_hash = HASH_SEED;
   bit                      filter_model [0:FILTER_SIZE-1];
   bffth_pkg::rsp_item_type expected_rsp [$];

   dir_row_type  dir_steps [0:DIR_ROWS-1];
   logic [7:0]   lib_name [0:LIB_SIZE-1][0:MAX_NAME-1];
   int           lib_len [0:LIB_SIZE-1];
   int           lib_count = 0;

   int  mismatch_cnt = 0;
   int  items_sent   = 0;
   int  insert_cnt   = 0;
   int  query_cnt    = 0;
   int  hit_cnt      = 0;
   int  rsp_cnt      = 0;
   int  stall_left   = 0;
   bit  req_burst    = 1'b0;
   bit  rsp_burst    = 1'b0;

   bloom_filter_fnv_three_hash uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // Fold one item into the name hash; on the last item probe or set the three bits.
   task automatic filter_step(input bffth_pkg::req_item_type it, output bit produced,
                              output bffth_pkg::rsp_item_type r);
      logic [63:0] h1, h2, h3;
      longint unsigned i1, i2, i3;
      produced = 1'b0;
      r = '0;
      if (it.no_byte == HAS_BYTE)
         name_hash = (name_hash ^ {{56{it.name_byte[7]}}, it.name_byte}) * HASH_PRIME;
      if (it.is_last == IS_LAST) begin
         h1 = name_hash;
         h2 = h1 * MIX_MULT;
         h3 = h1 ^ (h2 >> MIX_BITS);
         i1 = h1 % 64'(FILTER_SIZE);
         i2 = h2 % 64'(FILTER_SIZE);
         i3 = h3 % 64'(FILTER_SIZE);
         if (it.req_type == REQ_INSERT) begin
            filter_model[i1] = 1'b1;
            filter_model[i2] = 1'b1;
            filter_model[i3] = 1'b1;
            r.was_insert = 1'b1;
         end else begin
            r.maybe_present = filter_model[i1] & filter_model[i2] & filter_model[i3];
         end
         produced = 1'b1;
         name_hash = HASH_SEED;
      end
   endtask

   // Drive one item, wait for it to be taken, then record what it should produce.
   task automatic issue_item(input bffth_pkg::req_item_type it, input bit typed,
                             input bffth_pkg::rsp_item_type typed_rsp);
      int gap;
      bit produced;
      bffth_pkg::rsp_item_type r;
      gap = req_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
      filter_step(it, produced, r);
      if (produced) begin
         if (typed) r = typed_rsp;
         expected_rsp = {expected_rsp, r};
         if (it.req_type == REQ_INSERT) insert_cnt++;
         else query_cnt++;
      end
   endtask

   // Result side: hold stall for a drawn number of cycles after each result.
   always @(posedge clock) begin : rsp_pacer
      int draw;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end else if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if ($urandom_range(0, 39) == 0) rsp_burst = ~rsp_burst;
         draw = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
         stall_left <= draw;
         rsp_stall  <= (draw > 0);
      end
   end

   always @(posedge clock) begin : rsp_check
      bffth_pkg::rsp_item_type exp;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         rsp_cnt++;
         if (expected_rsp.size() == 0) begin
            $error("unexpected result: maybe_present %0d, was_insert %0d",
                   rsp_item.maybe_present, rsp_item.was_insert);
            mismatch_cnt++;
         end else begin
            exp = expected_rsp.pop_front();
            if (rsp_item.maybe_present !== exp.maybe_present) begin
               $error("maybe_present: expected %0d, got %0d",
                      exp.maybe_present, rsp_item.maybe_present);
               mismatch_cnt++;
            end
            if (rsp_item.was_insert !== exp.was_insert) begin
               $error("was_insert: expected %0d, got %0d",
                      exp.was_insert, rsp_item.was_insert);
               mismatch_cnt++;
            end
            if (exp.was_insert == 1'b0 && exp.maybe_present == 1'b1) hit_cnt++;
         end
      end
   end

   initial begin : stimulus
      bffth_pkg::req_item_type it;
      logic [7:0] name_bytes [0:MAX_NAME-1];
      int  name_len, pick, rand_items;
      logic kind;
      bit  replay, blank_tail, last_here;

      dir_steps = '{
         // empty name before and after it is inserted
         '{'{REQ_QUERY,  8'h00, IS_LAST,  NO_BYTE},  TYPED,   '{1'b0, 1'b0}},
         '{'{REQ_INSERT, 8'hFF, IS_LAST,  NO_BYTE},  TYPED,   '{1'b0, 1'b1}},
         '{'{REQ_QUERY,  8'h5A, IS_LAST,  NO_BYTE},  TYPED,   '{1'b1, 1'b0}},
         // request type on an earlier item is ignored
         '{'{REQ_QUERY,  8'h00, NOT_LAST, HAS_BYTE}, PREDICT, '{1'b0, 1'b0}},
         '{'{REQ_INSERT, 8'hFF, IS_LAST,  HAS_BYTE}, TYPED,   '{1'b0, 1'b1}},
         '{'{REQ_INSERT, 8'h00, NOT_LAST, HAS_BYTE}, PREDICT, '{1'b0, 1'b0}},
         '{'{REQ_QUERY,  8'hFF, IS_LAST,  HAS_BYTE}, PREDICT, '{1'b0, 1'b0}},
         // byteless items in the middle of a name change nothing
         '{'{REQ_QUERY,  8'hA5, NOT_LAST, NO_BYTE},  PREDICT, '{1'b0, 1'b0}},
         '{'{REQ_INSERT, 8'h7F, NOT_LAST, HAS_BYTE}, PREDICT, '{1'b0, 1'b0}},
         '{'{REQ_QUERY,  8'hFF, NOT_LAST, NO_BYTE},  PREDICT, '{1'b0, 1'b0}},
         '{'{REQ_INSERT, 8'h80, IS_LAST,  HAS_BYTE}, TYPED,   '{1'b0, 1'b1}},
         '{'{REQ_INSERT, 8'h7F, NOT_LAST, HAS_BYTE}, PREDICT, '{1'b0, 1'b0}},
         '{'{REQ_QUERY,  8'h80, IS_LAST,  HAS_BYTE}, PREDICT, '{1'b0, 1'b0}},
         // byteless last item closes a name made of earlier bytes
         '{'{REQ_INSERT, 8'h41, NOT_LAST, HAS_BYTE}, PREDICT, '{1'b0, 1'b0}},
         '{'{REQ_QUERY,  8'h00, IS_LAST,  NO_BYTE},  PREDICT, '{1'b0, 1'b0}},
         '{'{REQ_INSERT, 8'h41, IS_LAST,  HAS_BYTE}, TYPED,   '{1'b0, 1'b1}},
         '{'{REQ_QUERY,  8'h41, NOT_LAST, HAS_BYTE}, PREDICT, '{1'b0, 1'b0}},
         '{'{REQ_QUERY,  8'hC3, IS_LAST,  NO_BYTE},  PREDICT, '{1'b0, 1'b0}},
         '{'{REQ_QUERY,  8'h80, NOT_LAST, HAS_BYTE}, PREDICT, '{1'b0, 1'b0}},
         '{'{REQ_QUERY,  8'h7F, NOT_LAST, HAS_BYTE}, PREDICT, '{1'b0, 1'b0}},
         '{'{REQ_INSERT, 8'hFF, IS_LAST,  HAS_BYTE}, TYPED,   '{1'b0, 1'b1}},
         '{'{REQ_QUERY,  8'h00, IS_LAST,  HAS_BYTE}, PREDICT, '{1'b0, 1'b0}},
         '{'{REQ_QUERY,  8'h01, IS_LAST,  HAS_BYTE}, PREDICT, '{1'b0, 1'b0}}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         issue_item(dir_steps[i].item, dir_steps[i].typed, dir_steps[i].exp);

      rand_items = 0;
      while (rand_items < RAND_ITEMS) begin
         if ($urandom_range(0, 29) == 0) req_burst = ~req_burst;
         replay = (lib_count > 0) && ($urandom_range(0, 99) < 45);
         if (replay) begin
            pick = $urandom_range(0, lib_count - 1);
            name_len = lib_len[pick];
            for (int j = 0; j < MAX_NAME; j++) name_bytes[j] = lib_name[pick][j];
            kind = ($urandom_range(0, 99) < 70) ? REQ_QUERY : REQ_INSERT;
         end else begin
            name_len = $urandom_range(0, MAX_NAME);
            for (int j = 0; j < MAX_NAME; j++) begin
               if ($urandom_range(0, 3) == 0)
                  name_bytes[j] = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
               else
                  name_bytes[j] = 8'($urandom_range(0, 255));
            end
            kind = $urandom_range(0, 1) ? REQ_QUERY : REQ_INSERT;
            // remember inserted names so later queries can hit
            if (kind == REQ_INSERT) begin
               if (lib_count < LIB_SIZE) begin
                  pick = lib_count;
                  lib_count++;
               end else begin
                  pick = $urandom_range(0, LIB_SIZE - 1);
               end
               lib_len[pick] = name_len;
               for (int j = 0; j < MAX_NAME; j++) lib_name[pick][j] = name_bytes[j];
            end
         end
         blank_tail = (name_len == 0) || ($urandom_range(0, 99) < 15);

         for (int j = 0; j < name_len; j++) begin
            // noise: byteless filler inside the name
            if ($urandom_range(0, 7) == 0) begin
               it = '{req_type: 1'($urandom_range(0, 1)), name_byte: 8'($urandom_range(0, 255)),
                      is_last: NOT_LAST, no_byte: NO_BYTE};
               issue_item(it, PREDICT, '0);
               rand_items++;
            end
            last_here = (j == name_len - 1) && !blank_tail;
            it.req_type  = last_here ? kind : 1'($urandom_range(0, 1));
            it.name_byte = name_bytes[j];
            it.is_last   = last_here ? IS_LAST : NOT_LAST;
            it.no_byte   = HAS_BYTE;
            issue_item(it, PREDICT, '0);
            rand_items++;
         end
         if (blank_tail) begin
            it = '{req_type: kind, name_byte: 8'($urandom_range(0, 255)),
                   is_last: IS_LAST, no_byte: NO_BYTE};
            issue_item(it, PREDICT, '0);
            rand_items++;
         end
      end

      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d request items: %0d inserts and %0d queries, %0d query hits,",
               items_sent, insert_cnt, query_cnt, hit_cnt);
      $display("with %0d results checked and %0d mismatches.", rsp_cnt, mismatch_cnt);
      if (mismatch_cnt == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: files.f
sv/bffth_pkg.sv
sv/bffth_store.sv
sv/bffth_dp.sv
sv/bffth_ctrl.sv
sv/bloom_filter_fnv_three_hash.sv
sv/bffth_checker.sv
dv/bloom_filter_fnv_three_hash_tb.sv
